// ----- rtl/record_exchange_sort_macros.svh -----
// Assertion macros shared by the record exchange sort RTL.
// Included by the top level; depends on nothing else.
`ifndef RECORD_EXCHANGE_SORT_MACROS_SVH
`define RECORD_EXCHANGE_SORT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RXS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record_exchange_sort: assertion failed");

// next-cycle implication, disabled during reset
`define RXS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record_exchange_sort: assertion failed");

`endif

// ----- rtl/rxs_pkg.sv -----
// Package for the record exchange sort: widths, defaults, request opcodes
// and the controller-to-datapath command struct. No dependencies.
package rxs_pkg;

  localparam int ENTRIES_DEF     = 64;
  localparam int TITLE_BYTES_DEF = 20;
  localparam int CMD_W           = 2;
  localparam int SEL_W           = 2;
  localparam int WORD_W          = 64;
  localparam int VALUE_W         = 32;
  localparam int RECORD_W        = 6;

  typedef enum logic [CMD_W-1:0] {
    OP_LOAD_TITLE = 2'd0,
    OP_LOAD_VALUE = 2'd1,
    OP_SORT       = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  typedef struct packed {
    logic title_we;
    logic value_we;
    logic perm_we;
    logic perm_wsel_pi;
    logic perm_re;
    logic key_re;
    logic cap_pi;
    logic cap_key_i;
    logic swap;
  } rxs_cmd_t;

endpackage

// ----- rtl/rxs_ctrl.sv -----
// Controller for the record exchange sort: request decode, record count,
// sort loop counters and result strobes. Depends on rxs_pkg.
module rxs_ctrl #(
  parameter int ENTRIES     = rxs_pkg::ENTRIES_DEF,
  parameter int TITLE_BYTES = rxs_pkg::TITLE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rxs_pkg::CMD_W-1:0]  command,
  input  logic [rxs_pkg::SEL_W-1:0]  word_select,
  input  logic                       key_greater,
  output logic                       busy,
  output logic                       result_valid,
  output logic                       last,
  output rxs_pkg::rxs_cmd_t          cmd,
  output logic [$clog2(ENTRIES)-1:0] rec_addr,
  output logic [$clog2(ENTRIES)-1:0] perm_waddr,
  output logic [$clog2(ENTRIES)-1:0] perm_raddr
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TW = (TITLE_BYTES + 7) / 8;
  localparam int SW = rxs_pkg::SEL_W;

  typedef enum logic [3:0] {
    IDLE, INIT, OUTER_RD, OUTER_KEY, OUTER_CAP,
    INNER_RD, INNER_KEY, INNER_CMP, OUTER_END, EMIT
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [AW-1:0]   last_idx;
  logic [AW-1:0]   i;
  logic [AW-1:0]   j;
  logic [AW-1:0]   k;
  rxs_pkg::op_t    op;
  logic            has_room;

  assign op       = rxs_pkg::op_t'(command);
  assign has_room = count < CW'(ENTRIES);
  assign busy     = state != IDLE;
  assign rec_addr = count[AW-1:0];

  always_comb begin
    cmd        = '0;
    perm_waddr = k;
    perm_raddr = k;
    unique case (state)
      IDLE: begin
        if (start) begin
          unique case (op)
            rxs_pkg::OP_LOAD_TITLE: cmd.title_we = has_room && (word_select < SW'(TW));
            rxs_pkg::OP_LOAD_VALUE: cmd.value_we = has_room;
            rxs_pkg::OP_SORT, rxs_pkg::OP_UNUSED: ;
          endcase
        end
      end
      INIT: cmd.perm_we = 1'b1;
      OUTER_RD: begin
        cmd.perm_re = 1'b1;
        perm_raddr  = i;
      end
      OUTER_KEY: begin
        cmd.key_re = 1'b1;
        cmd.cap_pi = 1'b1;
      end
      OUTER_CAP: cmd.cap_key_i = 1'b1;
      INNER_RD: begin
        cmd.perm_re = 1'b1;
        perm_raddr  = j;
      end
      INNER_KEY: cmd.key_re = 1'b1;
      INNER_CMP: begin
        cmd.swap         = key_greater;
        cmd.perm_we      = key_greater;
        cmd.perm_wsel_pi = 1'b1;
        perm_waddr       = j;
      end
      OUTER_END: begin
        cmd.perm_we      = 1'b1;
        cmd.perm_wsel_pi = 1'b1;
        perm_waddr       = i;
      end
      EMIT: cmd.perm_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      count        <= '0;
      result_valid <= 1'b0;
      last         <= 1'b0;
    end else begin
      result_valid <= state == EMIT;
      last         <= (state == EMIT) && (k == last_idx);
      unique case (state)
        IDLE: begin
          if (start) begin
            unique case (op)
              rxs_pkg::OP_LOAD_VALUE: begin
                if (has_room) count <= count + CW'(1);
              end
              rxs_pkg::OP_SORT: begin
                if (count != '0) begin
                  last_idx <= AW'(count - CW'(1));
                  k        <= '0;
                  state    <= INIT;
                end
              end
              rxs_pkg::OP_LOAD_TITLE, rxs_pkg::OP_UNUSED: ;
            endcase
          end
        end
        INIT: begin
          if (k != last_idx) begin
            k <= k + AW'(1);
          end else if (last_idx == '0) begin
            k     <= '0;
            state <= EMIT;
          end else begin
            i     <= '0;
            state <= OUTER_RD;
          end
        end
        OUTER_RD:  state <= OUTER_KEY;
        OUTER_KEY: state <= OUTER_CAP;
        OUTER_CAP: begin
          j     <= i + AW'(1);
          state <= INNER_RD;
        end
        INNER_RD:  state <= INNER_KEY;
        INNER_KEY: state <= INNER_CMP;
        INNER_CMP: begin
          if (j == last_idx) begin
            state <= OUTER_END;
          end else begin
            j     <= j + AW'(1);
            state <= INNER_RD;
          end
        end
        OUTER_END: begin
          if (i == last_idx - AW'(1)) begin
            k     <= '0;
            state <= EMIT;
          end else begin
            i     <= i + AW'(1);
            state <= OUTER_RD;
          end
        end
        EMIT: begin
          k <= k + AW'(1);
          if (k == last_idx) begin
            count <= '0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rxs_data.sv -----
// Datapath for the record exchange sort: title, value and permutation
// memories, cached outer key and the key comparator. Depends on rxs_pkg.
module rxs_data #(
  parameter int ENTRIES     = rxs_pkg::ENTRIES_DEF,
  parameter int TITLE_BYTES = rxs_pkg::TITLE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rxs_pkg::rxs_cmd_t             cmd,
  input  logic [$clog2(ENTRIES)-1:0]    rec_addr,
  input  logic [$clog2(ENTRIES)-1:0]    perm_waddr,
  input  logic [$clog2(ENTRIES)-1:0]    perm_raddr,
  input  logic [rxs_pkg::SEL_W-1:0]     word_select,
  input  logic [rxs_pkg::WORD_W-1:0]    title_word,
  input  logic [rxs_pkg::VALUE_W-1:0]   book_value,
  input  logic                          cfg_we,
  input  logic                          cfg_sort_key,
  output logic                          key_greater,
  output logic [rxs_pkg::RECORD_W-1:0]  record_number
);

  localparam int AW = $clog2(ENTRIES);
  localparam int TW = (TITLE_BYTES + 7) / 8;
  localparam int NB = TITLE_BYTES;
  localparam int WW = rxs_pkg::WORD_W;
  localparam int VW = rxs_pkg::VALUE_W;
  localparam int RW = rxs_pkg::RECORD_W;
  localparam int SW = rxs_pkg::SEL_W;

  logic                   sort_key;
  logic [AW-1:0]          perm_mem [ENTRIES];
  logic [AW-1:0]          perm_rdata;
  logic [VW-1:0]          value_mem [ENTRIES];
  logic [VW-1:0]          value_rd;
  logic [TW-1:0][WW-1:0]  title_rd;
  logic [AW-1:0]          pi;
  logic [AW-1:0]          pj;
  logic [TW-1:0][WW-1:0]  title_i;
  logic [VW-1:0]          value_i;
  logic [NB-1:0]          g_vec;
  logic [NB-1:0]          l_vec;
  logic                   value_gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key <= 1'b0;
    end else if (cfg_we) begin
      sort_key <= cfg_sort_key;
    end
  end

  for (genvar w = 0; w < TW; w++) begin : gen_word
    logic [WW-1:0] title_mem [ENTRIES];

    always_ff @(posedge clk) begin
      if (cmd.title_we && word_select == SW'(w)) title_mem[rec_addr] <= title_word;
      if (cmd.key_re) title_rd[w] <= title_mem[perm_rdata];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.value_we) value_mem[rec_addr] <= book_value;
    if (cmd.key_re) value_rd <= value_mem[perm_rdata];
  end

  always_ff @(posedge clk) begin
    if (cmd.perm_we) perm_mem[perm_waddr] <= cmd.perm_wsel_pi ? pi : perm_waddr;
    if (cmd.perm_re) perm_rdata <= perm_mem[perm_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.key_re) pj <= perm_rdata;
    if (cmd.cap_pi) begin
      pi <= perm_rdata;
    end else if (cmd.swap) begin
      pi <= pj;
    end
    if (cmd.cap_key_i || cmd.swap) begin
      title_i <= title_rd;
      value_i <= value_rd;
    end
  end

  // flag each byte that ends the string compare, split by which side is larger
  for (genvar b = 0; b < NB; b++) begin : gen_byte
    localparam int WI = b / 8;
    localparam int HI = WW - 1 - 8 * (b % 8);
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       stop;

    assign byte_a           = title_i[WI][HI -: 8];
    assign byte_b           = title_rd[WI][HI -: 8];
    assign stop             = (byte_a != byte_b) || (byte_a == 8'd0);
    assign g_vec[NB-1-b]    = stop && (byte_a > byte_b);
    assign l_vec[NB-1-b]    = stop && !(byte_a > byte_b);
  end

  assign value_gt      = $signed(value_i) > $signed(value_rd);
  assign key_greater   = sort_key ? value_gt : (g_vec > l_vec);
  assign record_number = RW'(perm_rdata);

endmodule

// ----- rtl/record_exchange_sort.sv -----
// Top level of the record exchange sort: controller plus datapath.
// Depends on rxs_pkg, rxs_ctrl, rxs_data and record_exchange_sort_macros.svh.
//
// Usage:
//   Requests enter on start while busy is low. Title-word and value loads
//   keep busy low, so a load may follow every cycle; a value load commits
//   the record. Loads beyond ENTRIES records are dropped. A sort request
//   raises busy for the whole run: one permutation write per record, then
//   for each key comparison a permutation read, a key read and a compare
//   and swap in turn, as each memory has a single read port, then one
//   result per cycle. A sort with no records returns nothing.
//   Results appear on record_number and last with result_valid high for one
//   cycle each, back to back; the receiver cannot stall them. last marks the
//   final record, and the record count is then cleared.
//   The sort_key register is written through cfg_valid/cfg_ready while idle.
//   Reset clears the count, the sort_key register and the control state;
//   the memories are not cleared.
`include "record_exchange_sort_macros.svh"

module record_exchange_sort #(
  parameter int ENTRIES     = rxs_pkg::ENTRIES_DEF,
  parameter int TITLE_BYTES = rxs_pkg::TITLE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rxs_pkg::CMD_W-1:0]     command,
  input  logic [rxs_pkg::SEL_W-1:0]     word_select,
  input  logic [rxs_pkg::WORD_W-1:0]    title_word,
  input  logic [rxs_pkg::VALUE_W-1:0]   book_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          sort_key,
  output logic                          result_valid,
  output logic [rxs_pkg::RECORD_W-1:0]  record_number,
  output logic                          last
);

  localparam int AW = $clog2(ENTRIES);

  rxs_pkg::rxs_cmd_t cmd;
  logic [AW-1:0]     rec_addr;
  logic [AW-1:0]     perm_waddr;
  logic [AW-1:0]     perm_raddr;
  logic              key_greater;

  assign cfg_ready = !busy;

  rxs_ctrl #(
    .ENTRIES     (ENTRIES),
    .TITLE_BYTES (TITLE_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .word_select  (word_select),
    .key_greater  (key_greater),
    .busy         (busy),
    .result_valid (result_valid),
    .last         (last),
    .cmd          (cmd),
    .rec_addr     (rec_addr),
    .perm_waddr   (perm_waddr),
    .perm_raddr   (perm_raddr)
  );

  rxs_data #(
    .ENTRIES     (ENTRIES),
    .TITLE_BYTES (TITLE_BYTES)
  ) u_data (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rec_addr      (rec_addr),
    .perm_waddr    (perm_waddr),
    .perm_raddr    (perm_raddr),
    .word_select   (word_select),
    .title_word    (title_word),
    .book_value    (book_value),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_sort_key  (sort_key),
    .key_greater   (key_greater),
    .record_number (record_number)
  );

  `RXS_ASSERT_IMPLY(a_result_from_run, clk, rst, result_valid, $past(busy))
  `RXS_ASSERT_NEXT(a_run_contiguous, clk, rst, result_valid && !last, result_valid)
  `RXS_ASSERT_NEXT(a_last_ends_run, clk, rst, result_valid && last, !result_valid && !busy)

endmodule

// ----- test/rxs_sort_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the record exchange sort: follows loads, sort_key writes and
// sort requests, predicts each sorted run and checks the result stream.
// Depends on rxs_pkg only.
module rxs_sort_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [rxs_pkg::CMD_W-1:0]    command,
  input  logic [rxs_pkg::SEL_W-1:0]    word_select,
  input  logic [rxs_pkg::WORD_W-1:0]   title_word,
  input  logic [rxs_pkg::VALUE_W-1:0]  book_value,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         sort_key,
  input  logic                         result_valid,
  input  logic [rxs_pkg::RECORD_W-1:0] record_number,
  input  logic                         last,
  output int                           fail_count,
  output int                           pending
);
  import rxs_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEF;
  localparam int TITLE_BYTES = TITLE_BYTES_DEF;
  localparam int TITLE_WORDS = (TITLE_BYTES + 7) / 8;

  typedef struct packed {
    logic [RECORD_W-1:0] number;
    logic                is_last;
  } sorted_slot_t;

  logic [WORD_W-1:0]  title_mem [ENTRIES][TITLE_WORDS];
  logic [VALUE_W-1:0] value_mem [ENTRIES];
  int                 stored_count = 0;
  logic               by_value = 1'b0;
  sorted_slot_t       sorted_q [$];
  int                 mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic key_above(int a, int b);
    logic [WORD_W-1:0] wa;
    logic [WORD_W-1:0] wb;
    logic [7:0]        ca;
    logic [7:0]        cb;
    if (by_value) return $signed(value_mem[a]) > $signed(value_mem[b]);
    for (int i = 0; i < TITLE_BYTES; i++) begin
      wa = title_mem[a][i / 8];
      wb = title_mem[b][i / 8];
      ca = 8'(wa >> (56 - 8 * (i % 8)));
      cb = 8'(wb >> (56 - 8 * (i % 8)));
      if (ca != cb) return ca > cb;
      if (ca == 8'h00) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic void queue_sorted_run();
    logic [RECORD_W-1:0] order [ENTRIES];
    logic [RECORD_W-1:0] held;
    sorted_slot_t        slot;
    for (int i = 0; i < stored_count; i++) order[i] = RECORD_W'(i);
    for (int i = 0; i + 1 < stored_count; i++) begin
      for (int j = i + 1; j < stored_count; j++) begin
        if (key_above(order[i], order[j])) begin
          held     = order[i];
          order[i] = order[j];
          order[j] = held;
        end
      end
    end
    for (int k = 0; k < stored_count; k++) begin
      slot.number  = order[k];
      slot.is_last = (k == stored_count - 1);
      sorted_q.push_back(slot);
    end
    stored_count = 0;
  endfunction

  always @(posedge clk) begin : watch
    sorted_slot_t want;
    if (rst) begin
      stored_count = 0;
      by_value     = 1'b0;
      sorted_q.delete();
    end else begin
      if (result_valid) begin
        if (sorted_q.size() == 0) begin
          $error("record_number: expected nothing, got %0d", record_number);
          mismatches++;
        end else begin
          want = sorted_q.pop_front();
          if (record_number !== want.number) begin
            $error("record_number: expected %0d, got %0d", want.number, record_number);
            mismatches++;
          end
          if (last !== want.is_last) begin
            $error("last: expected %0d, got %0d", want.is_last, last);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) by_value = sort_key;
      if (start && !busy) begin
        case (op_t'(command))
          OP_LOAD_TITLE: begin
            if (stored_count < ENTRIES && word_select < TITLE_WORDS)
              title_mem[stored_count][word_select] = title_word;
          end
          OP_LOAD_VALUE: begin
            if (stored_count < ENTRIES) begin
              value_mem[stored_count] = book_value;
              stored_count++;
            end
          end
          OP_SORT: queue_sorted_run();
          default: ;
        endcase
      end
    end
    pending    <= sorted_q.size();
    fail_count <= mismatches;
  end

endmodule

// ----- test/tb_record_exchange_sort.sv -----
`timescale 1ns / 100ps
// Top of the record exchange sort testbench: clock, reset, the block and its
// scoreboard; drives load, sort and sort_key requests and gives the verdict.
// Depends on rxs_pkg, record_exchange_sort and rxs_sort_checker.
module tb_record_exchange_sort;
  import rxs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 430;
  localparam int SLOTS        = ENTRIES_DEF;
  localparam int TITLE_WORDS  = (TITLE_BYTES_DEF + 7) / 8;
  localparam int TITLE_BITS   = WORD_W * TITLE_WORDS;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                start       = 1'b0;
  logic [CMD_W-1:0]    command     = OP_UNUSED;
  logic [SEL_W-1:0]    word_select = '0;
  logic [WORD_W-1:0]   title_word  = '0;
  logic [VALUE_W-1:0]  book_value  = '0;
  logic                cfg_valid   = 1'b0;
  logic                sort_key    = 1'b0;
  logic                busy;
  logic                cfg_ready;
  logic                result_valid;
  logic [RECORD_W-1:0] record_number;
  logic                last;
  int                  fail_count;
  int                  pending;
  int                  cycles      = 0;
  int                  items       = 0;
  int                  loaded      = 0;
  bit                  allow_gaps  = 1'b0;
  bit                  word_written [SLOTS][TITLE_WORDS];

  always #1 clk = ~clk;

  record_exchange_sort dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .word_select  (word_select),
    .title_word   (title_word),
    .book_value   (book_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .sort_key     (sort_key),
    .result_valid (result_valid),
    .record_number(record_number),
    .last         (last)
  );

  rxs_sort_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .word_select  (word_select),
    .title_word   (title_word),
    .book_value   (book_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .sort_key     (sort_key),
    .result_valid (result_valid),
    .record_number(record_number),
    .last         (last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return VALUE_W'($urandom_range(0, 3)) - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TITLE_BITS-1:0] rand_title();
    logic [TITLE_BITS-1:0] text;
    logic [7:0]            ch;
    int                    len;
    int                    style;
    text = '0;
    text[TITLE_BITS-1-8*TITLE_BYTES_DEF:0] = $urandom;
    style = $urandom_range(0, 3);
    len = ($urandom_range(0, 3) == 0) ? TITLE_BYTES_DEF : $urandom_range(0, TITLE_BYTES_DEF);
    for (int i = 0; i < TITLE_BYTES_DEF; i++) begin
      case (style)
        0: ch = 8'h41 + 8'($urandom_range(0, 2));
        1: ch = 8'($urandom_range(1, 255));
        2: ch = $urandom_range(0, 1) ? 8'hFF : 8'h01;
        default: ch = (i + 1 < len) ? 8'h4D : 8'($urandom_range(1, 255));
      endcase
      if (i < len) text[TITLE_BITS-1-8*i -: 8] = ch;
      else if (i > len && $urandom_range(0, 7) == 0) text[TITLE_BITS-1-8*i -: 8] = ch;
    end
    return text;
  endfunction

  task automatic send(op_t op, logic [SEL_W-1:0] sel, logic [WORD_W-1:0] word,
                      logic [VALUE_W-1:0] val);
    if (allow_gaps && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start       <= 1'b1;
    command     <= op;
    word_select <= sel;
    title_word  <= word;
    book_value  <= val;
    items++;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sort_key(logic key);
    settle();
    cfg_valid <= 1'b1;
    sort_key  <= key;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // fresh slots get every title word; reused slots keep some old words
  task automatic load_record(logic [TITLE_BITS-1:0] text, logic [VALUE_W-1:0] val);
    int first;
    int sel;
    first = $urandom_range(0, TITLE_WORDS - 1);
    if ($urandom_range(0, 11) == 0) send(OP_UNUSED, SEL_W'($urandom), rand_word(), $urandom);
    if ($urandom_range(0, 11) == 0) send(OP_LOAD_TITLE, 2'd3, rand_word(), $urandom);
    for (int k = 0; k < TITLE_WORDS; k++) begin
      sel = (first + k) % TITLE_WORDS;
      if (loaded >= SLOTS || !word_written[loaded][sel] || $urandom_range(0, 1)) begin
        if ($urandom_range(0, 9) == 0)
          send(OP_LOAD_TITLE, SEL_W'(sel), rand_word(), $urandom);
        send(OP_LOAD_TITLE, SEL_W'(sel), text[TITLE_BITS-1-WORD_W*sel -: WORD_W], $urandom);
        if (loaded < SLOTS) word_written[loaded][sel] = 1'b1;
      end
    end
    send(OP_LOAD_VALUE, SEL_W'($urandom), rand_word(), val);
    if (loaded < SLOTS) loaded++;
  endtask

  task automatic run_sort();
    send(OP_SORT, SEL_W'($urandom), rand_word(), $urandom);
    loaded = 0;
  endtask

  initial begin
    int batch;
    int pick;
    int count;
    int sel;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_sort();
    send(OP_UNUSED, SEL_W'($urandom), rand_word(), $urandom);
    load_record('0, 32'h7FFF_FFFF);
    load_record({{20{8'hFF}}, $urandom}, 32'h8000_0000);
    load_record({8'h01, 184'h0}, 32'h0000_0000);
    send(OP_LOAD_TITLE, 2'd3, {64{1'b1}}, $urandom);
    load_record({{20{8'hFF}}, $urandom}, 32'hFFFF_FFFF);
    run_sort();
    write_sort_key(1'b1);
    send(OP_LOAD_VALUE, 2'd0, '0, 32'h8000_0000);
    send(OP_LOAD_VALUE, 2'd1, '1, 32'h7FFF_FFFF);
    send(OP_LOAD_VALUE, 2'd2, '0, 32'hFFFF_FFFF);
    send(OP_LOAD_VALUE, 2'd3, '1, 32'h0000_0000);
    loaded = 4;
    run_sort();

    write_sort_key(1'b0);
    allow_gaps = 1'b1;
    batch = 0;
    while (items < RANDOM_ITEMS) begin
      if (batch > 0 && $urandom_range(0, 2) == 0) write_sort_key(1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 19);
      if (batch == 3 || $urandom_range(0, 59) == 0) count = SLOTS + $urandom_range(1, 3);
      else if (pick == 0) count = 0;
      else if (pick < 15) count = $urandom_range(1, 6);
      else if (pick < 19) count = $urandom_range(7, 20);
      else count = $urandom_range(21, 40);
      for (int r = 0; r < count; r++) load_record(rand_title(), rand_value());
      if ($urandom_range(0, 9) == 0) begin
        sel = $urandom_range(0, TITLE_WORDS - 1);
        send(OP_LOAD_TITLE, SEL_W'(sel), rand_word(), $urandom);
        if (loaded < SLOTS) word_written[loaded][sel] = 1'b1;
      end
      run_sort();
      batch++;
      allow_gaps = (items < RANDOM_ITEMS * 85 / 100) && ($urandom_range(0, 3) != 0);
    end

    settle();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
